// File: hw/rtl/frt_pkg.sv
// Shared constants, op codes and transfer structs for the fragment reassembly tracker.
`timescale 1ns / 1ps
`default_nettype none

package frt_pkg;

    localparam int MAX_CHUNKS  = 64;
    localparam int CHUNK_BYTES = 220;
    localparam int STORE_BYTES = MAX_CHUNKS * CHUNK_BYTES;

    localparam int OP_W     = 2;
    localparam int SEQ_W    = 8;
    localparam int IDX_W    = 8;
    localparam int DATA_W   = 8;
    localparam int ADDR_W   = 14;
    localparam int CNT_W    = 7;
    localparam int LEN_W    = 14;
    localparam int MAP_IDX_W = $clog2(MAX_CHUNKS);

    localparam logic [OP_W-1:0] OP_DATA  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SEQ_W-1:0]  seq_num;
        logic [IDX_W-1:0]  byte_index;
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
        logic [ADDR_W-1:0] read_address;
    } frt_item_t;

    typedef struct packed {
        logic              accepted;
        logic              newly_received;
        logic              complete;
        logic [CNT_W-1:0]  received_count;
        logic              chunk_present;
        logic              read_sel;
        logic [LEN_W-1:0]  assembled_length;
        logic [LEN_W-1:0]  new_byte_total;
    } frt_result_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } frt_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/frt_store.sv
// Assembly buffer: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module frt_store
    import frt_pkg::*;
(
    input  wire logic              clk,
    input  wire frt_wr_t           wr,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:STORE_BYTES-1];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/frt_tracker.sv
// Chunk bitmap, counters and per-item decision logic.
`timescale 1ns / 1ps
`default_nettype none

module frt_tracker
    import frt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CNT_W-1:0] cfg_data,
    input  wire logic             item_valid,
    input  wire frt_item_t        item,
    output frt_result_t           res,
    output frt_wr_t               wr,
    output logic                  rd_en
);

    logic [CNT_W-1:0]      expected_reg, expected_next;
    logic [MAX_CHUNKS-1:0] map_reg, map_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [LEN_W-1:0]      bytes_reg, bytes_next;
    logic [LEN_W-1:0]      length_reg, length_next;

    logic [CNT_W-1:0]     lim;
    logic [MAP_IDX_W-1:0] seq_idx;
    logic                 seq_ok;
    logic                 idx_ok;
    logic [ADDR_W-1:0]    pos;
    logic [LEN_W-1:0]     end_off;

    always_comb
    begin
        // Counts above the bitmap size saturate.
        lim = (expected_reg > CNT_W'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS) : expected_reg;
        seq_idx = item.seq_num[MAP_IDX_W-1:0];
        seq_ok  = item.seq_num < {1'b0, lim};
        idx_ok  = {1'b0, item.byte_index} < (IDX_W + 1)'(CHUNK_BYTES);
        pos     = ADDR_W'(seq_idx) * ADDR_W'(CHUNK_BYTES) + ADDR_W'(item.byte_index);
        end_off = LEN_W'(pos) + LEN_W'(1);

        expected_next = expected_reg;
        map_next      = map_reg;
        total_next    = total_reg;
        bytes_next    = bytes_reg;
        length_next   = length_reg;
        res           = '0;
        wr            = '0;
        rd_en         = 1'b0;

        if (item_valid)
        begin
            case (item.op)
                OP_DATA:
                begin
                    if (seq_ok && idx_ok)
                    begin
                        res.accepted = 1'b1;
                        wr.en   = 1'b1;
                        wr.addr = pos;
                        wr.data = item.data_byte;
                        if (end_off > length_reg)
                        begin
                            length_next = end_off;
                        end
                        if (item.last_byte && !map_reg[seq_idx])
                        begin
                            map_next[seq_idx]  = 1'b1;
                            total_next         = total_reg + CNT_W'(1);
                            bytes_next         = bytes_reg + LEN_W'(item.byte_index)
                                                 + LEN_W'(1);
                            res.newly_received = 1'b1;
                        end
                        res.complete = total_next >= lim;
                    end
                end
                OP_QUERY:
                begin
                    res.chunk_present = seq_ok && map_reg[seq_idx];
                end
                OP_READ:
                begin
                    rd_en        = item.read_address < ADDR_W'(STORE_BYTES);
                    res.read_sel = rd_en;
                end
                default:
                begin
                end
            endcase
        end

        res.received_count   = total_next;
        res.assembled_length = length_next;
        res.new_byte_total   = bytes_next;

        // A new expected count restarts reassembly; the buffer keeps its bytes.
        if (cfg_we)
        begin
            expected_next = cfg_data;
            map_next      = '0;
            total_next    = '0;
            bytes_next    = '0;
            length_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= '0;
            map_reg      <= '0;
            total_reg    <= '0;
            bytes_reg    <= '0;
            length_reg   <= '0;
        end
        else
        begin
            expected_reg <= expected_next;
            map_reg      <= map_next;
            total_reg    <= total_next;
            bytes_reg    <= bytes_next;
            length_reg   <= length_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fragment_reassembly_tracker_core.sv
// Top level of the fragment reassembly tracker: input register, tracker, buffer, result register.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+----------------------------------------------------------
//  command  | start, busy        | op, seq_num, byte_index, data_byte, last_byte, read_address
//  result   | result_valid       | accepted, newly_received, complete, received_count,
//           |                    | chunk_present, read_data, assembled_length, new_byte_total
//  config   | cfg_we             | cfg_data (expected chunk count)
//
// A command transfer happens when start is high and busy is low; one can follow every cycle while busy stays low.
// Each result shows up on result_valid once its command has passed through the input
// register and the result register around the tracker logic and the buffer read port.
// Reset clears the bitmap, counters and expected count; buffer contents stay undefined.
// The receiver cannot stall, and busy is high only during a configuration write.
`timescale 1ns / 1ps
`default_nettype none

module fragment_reassembly_tracker_core
    import frt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CNT_W-1:0]  cfg_data,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   op,
    input  wire logic [SEQ_W-1:0]  seq_num,
    input  wire logic [IDX_W-1:0]  byte_index,
    input  wire logic [DATA_W-1:0] data_byte,
    input  wire logic              last_byte,
    input  wire logic [ADDR_W-1:0] read_address,
    output logic                   result_valid,
    output logic                   accepted,
    output logic                   newly_received,
    output logic                   complete,
    output logic      [CNT_W-1:0]  received_count,
    output logic                   chunk_present,
    output logic      [DATA_W-1:0] read_data,
    output logic      [LEN_W-1:0]  assembled_length,
    output logic      [LEN_W-1:0]  new_byte_total
);

    logic        in_valid_reg;
    frt_item_t   item_reg;
    logic        result_valid_reg;
    frt_result_t result_reg;

    frt_result_t       res;
    frt_wr_t           wr;
    logic              rd_en;
    logic [DATA_W-1:0] store_rdata;
    logic              take;

    assign busy = cfg_we;
    assign take = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= take;
            result_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.op           <= op;
            item_reg.seq_num      <= seq_num;
            item_reg.byte_index   <= byte_index;
            item_reg.data_byte    <= data_byte;
            item_reg.last_byte    <= last_byte;
            item_reg.read_address <= read_address;
        end
        if (in_valid_reg)
        begin
            result_reg <= res;
        end
    end

    frt_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .item_valid (in_valid_reg),
        .item       (item_reg),
        .res        (res),
        .wr         (wr),
        .rd_en      (rd_en)
    );

    frt_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (item_reg.read_address),
        .rd_data (store_rdata)
    );

    assign result_valid     = result_valid_reg;
    assign accepted         = result_reg.accepted;
    assign newly_received   = result_reg.newly_received;
    assign complete         = result_reg.complete;
    assign received_count   = result_reg.received_count;
    assign chunk_present    = result_reg.chunk_present;
    assign read_data        = result_reg.read_sel ? store_rdata : '0;
    assign assembled_length = result_reg.assembled_length;
    assign new_byte_total   = result_reg.new_byte_total;

endmodule

`default_nettype wire

// File: hw/rtl/frt_checker.sv
// Port-level checks for the fragment reassembly tracker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module frt_checker
    import frt_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              result_valid,
    input wire logic              accepted,
    input wire logic              newly_received,
    input wire logic              complete,
    input wire logic [CNT_W-1:0]  received_count,
    input wire logic              chunk_present,
    input wire logic [DATA_W-1:0] read_data,
    input wire logic [LEN_W-1:0]  assembled_length
);

    // Every command transfer yields exactly one result.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 result_valid)
        else $error("command transfer without a result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##2 !result_valid)
        else $error("result without a command transfer");

    a_fresh_implies_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (newly_received || complete)) |-> accepted)
        else $error("chunk flags on a rejected or non-data command");

    a_query_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && chunk_present) |-> (!accepted && read_data == '0))
        else $error("query result mixed with data or read fields");

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (received_count <= CNT_W'(MAX_CHUNKS)
                          && assembled_length <= LEN_W'(STORE_BYTES)))
        else $error("counter beyond the message size");

endmodule

bind fragment_reassembly_tracker_core frt_checker u_frt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .result_valid     (result_valid),
    .accepted         (accepted),
    .newly_received   (newly_received),
    .complete         (complete),
    .received_count   (received_count),
    .chunk_present    (chunk_present),
    .read_data        (read_data),
    .assembled_length (assembled_length)
);

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for fragment_reassembly_tracker_core with directed and random traffic.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import frt_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam int RESULT_LATENCY = 2;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int ADDR_TOP       = (1 << ADDR_W) - 1;

    typedef struct packed {
        logic              accepted;
        logic              newly_received;
        logic              complete;
        logic [CNT_W-1:0]  received_count;
        logic              chunk_present;
        logic [DATA_W-1:0] read_data;
        logic [LEN_W-1:0]  assembled_length;
        logic [LEN_W-1:0]  new_byte_total;
    } chunk_status_t;

    // Mirror of the tracker state; predicts the status of every accepted command transfer.
    class reassembly_mirror;
        logic [CNT_W-1:0]      chunk_goal;
        logic [MAX_CHUNKS-1:0] chunk_map;
        logic [CNT_W-1:0]      chunk_total;
        logic [LEN_W-1:0]      first_byte_total;
        logic [LEN_W-1:0]      high_water;
        logic [DATA_W-1:0]     store [STORE_BYTES];
        bit                    written [STORE_BYTES];
        int                    written_addrs [$];
        chunk_status_t         status_queue [$];
        int                    errors;

        function new();
            chunk_goal = '0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            chunk_map = '0;
            chunk_total = '0;
            first_byte_total = '0;
            high_water = '0;
        endfunction

        function void set_expected(logic [CNT_W-1:0] value);
            chunk_goal = value;
            restart();
        endfunction

        function void absorb_command(frt_item_t cmd);
            chunk_status_t st;
            int limit;
            int pos;
            st = '0;
            limit = (chunk_goal > MAX_CHUNKS) ? MAX_CHUNKS : int'(chunk_goal);
            case (cmd.op)
                OP_DATA:
                begin
                    if (cmd.seq_num < limit && cmd.byte_index < CHUNK_BYTES)
                    begin
                        pos = cmd.seq_num * CHUNK_BYTES + cmd.byte_index;
                        st.accepted = 1'b1;
                        store[pos] = cmd.data_byte;
                        if (!written[pos])
                        begin
                            written[pos] = 1'b1;
                            written_addrs.push_back(pos);
                        end
                        if (pos + 1 > high_water)
                            high_water = LEN_W'(pos + 1);
                        if (cmd.last_byte && !chunk_map[cmd.seq_num])
                        begin
                            chunk_map[cmd.seq_num] = 1'b1;
                            chunk_total = chunk_total + 1'b1;
                            first_byte_total = first_byte_total + cmd.byte_index + 1'b1;
                            st.newly_received = 1'b1;
                        end
                        st.complete = (chunk_total >= limit);
                    end
                end
                OP_QUERY: st.chunk_present = (cmd.seq_num < limit) && chunk_map[cmd.seq_num];
                OP_READ:
                begin
                    if (cmd.read_address < STORE_BYTES)
                        st.read_data = store[cmd.read_address];
                end
                default: ;
            endcase
            st.received_count = chunk_total;
            st.assembled_length = high_water;
            st.new_byte_total = first_byte_total;
            status_queue.push_back(st);
        endfunction

        function void compare_field(string name, logic [LEN_W-1:0] want, logic [LEN_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_status(chunk_status_t got);
            chunk_status_t want;
            if (status_queue.size() == 0)
            begin
                $display("%0t: result transfer with no command outstanding", $time);
                errors++;
                return;
            end
            want = status_queue.pop_front();
            compare_field("accepted", LEN_W'(want.accepted), LEN_W'(got.accepted));
            compare_field("newly_received", LEN_W'(want.newly_received),
                          LEN_W'(got.newly_received));
            compare_field("complete", LEN_W'(want.complete), LEN_W'(got.complete));
            compare_field("received_count", LEN_W'(want.received_count),
                          LEN_W'(got.received_count));
            compare_field("chunk_present", LEN_W'(want.chunk_present),
                          LEN_W'(got.chunk_present));
            compare_field("read_data", LEN_W'(want.read_data), LEN_W'(got.read_data));
            compare_field("assembled_length", want.assembled_length, got.assembled_length);
            compare_field("new_byte_total", want.new_byte_total, got.new_byte_total);
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [CNT_W-1:0]  cfg_data;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   op;
    logic [SEQ_W-1:0]  seq_num;
    logic [IDX_W-1:0]  byte_index;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
    logic [ADDR_W-1:0] read_address;
    logic              result_valid;
    logic              accepted;
    logic              newly_received;
    logic              complete;
    logic [CNT_W-1:0]  received_count;
    logic              chunk_present;
    logic [DATA_W-1:0] read_data;
    logic [LEN_W-1:0]  assembled_length;
    logic [LEN_W-1:0]  new_byte_total;

    reassembly_mirror mirror = new();
    int idle_pct;
    int quiet_cycles;

    fragment_reassembly_tracker_core uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .start            (start),
        .busy             (busy),
        .op               (op),
        .seq_num          (seq_num),
        .byte_index       (byte_index),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .read_address     (read_address),
        .result_valid     (result_valid),
        .accepted         (accepted),
        .newly_received   (newly_received),
        .complete         (complete),
        .received_count   (received_count),
        .chunk_present    (chunk_present),
        .read_data        (read_data),
        .assembled_length (assembled_length),
        .new_byte_total   (new_byte_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin : monitor
        bit moved;
        moved = 1'b0;
        if (rst_n && start && busy === 1'b0)
        begin
            mirror.absorb_command({op, seq_num, byte_index, data_byte, last_byte, read_address});
            moved = 1'b1;
        end
        if (rst_n && result_valid === 1'b1)
        begin
            mirror.check_status({accepted, newly_received, complete, received_count,
                                 chunk_present, read_data, assembled_length, new_byte_total});
            moved = 1'b1;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with no transfer", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic frt_item_t random_command(logic [OP_W-1:0] kind);
        frt_item_t cmd;
        cmd.op = kind;
        cmd.seq_num = SEQ_W'($urandom_range(0, 255));
        cmd.byte_index = IDX_W'($urandom_range(0, 255));
        cmd.data_byte = DATA_W'($urandom_range(0, 255));
        cmd.last_byte = 1'($urandom_range(0, 1));
        cmd.read_address = ADDR_W'($urandom_range(0, ADDR_TOP));
        return cmd;
    endfunction

    // Only stored bytes that were written, or addresses past the buffer, may be read back.
    function automatic int pick_read_address();
        if (mirror.written_addrs.size() == 0 || $urandom_range(0, 4) == 0)
            return $urandom_range(STORE_BYTES, ADDR_TOP);
        return mirror.written_addrs[$urandom_range(0, mirror.written_addrs.size() - 1)];
    endfunction

    task automatic send_command(frt_item_t cmd);
        int n;
        op <= cmd.op;
        seq_num <= cmd.seq_num;
        byte_index <= cmd.byte_index;
        data_byte <= cmd.data_byte;
        last_byte <= cmd.last_byte;
        read_address <= cmd.read_address;
        start <= 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            n = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_byte(int seq, int idx, logic [DATA_W-1:0] value, bit last);
        frt_item_t cmd;
        cmd = random_command(OP_DATA);
        cmd.seq_num = SEQ_W'(seq);
        cmd.byte_index = IDX_W'(idx);
        cmd.data_byte = value;
        cmd.last_byte = last;
        send_command(cmd);
    endtask

    task automatic send_query(int seq);
        frt_item_t cmd;
        cmd = random_command(OP_QUERY);
        cmd.seq_num = SEQ_W'(seq);
        send_command(cmd);
    endtask

    task automatic send_read(int addr);
        frt_item_t cmd;
        cmd = random_command(OP_READ);
        cmd.read_address = ADDR_W'(addr);
        send_command(cmd);
    endtask

    task automatic send_chunk(int seq, int len, bit finish);
        for (int i = 0; i < len; i++)
            send_byte(seq, i, DATA_W'($urandom_range(0, 255)), finish && (i == len - 1));
    endtask

    // The count register may only change once every result has come back.
    task automatic write_expected(logic [CNT_W-1:0] value);
        start <= 1'b0;
        while (mirror.status_queue.size() != 0) @(posedge clk);
        repeat (RESULT_LATENCY + 2) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        mirror.set_expected(value);
        cfg_we <= 1'b0;
    endtask

    task automatic directed_checks();
        frt_item_t cmd;
        // The count is still zero from reset, so even chunk zero is refused.
        send_byte(0, 0, 8'h3C, 1'b1);
        send_query(0);
        write_expected(7'd3);
        send_byte(0, 0, 8'h00, 1'b0);
        send_byte(0, CHUNK_BYTES - 1, 8'hFF, 1'b1);
        send_byte(0, 5, 8'hA5, 1'b1);
        send_byte(3, 0, 8'h11, 1'b1);
        send_byte(255, 255, 8'hFF, 1'b1);
        send_byte(1, CHUNK_BYTES, 8'h22, 1'b1);
        send_byte(1, 0, 8'h5A, 1'b1);
        send_query(0);
        send_query(1);
        send_query(2);
        send_query(255);
        send_read(0);
        send_read(CHUNK_BYTES - 1);
        send_read(5);
        send_read(STORE_BYTES);
        send_read(ADDR_TOP);
        cmd = '1;
        send_command(cmd);
        send_byte(2, 100, 8'h80, 1'b1);
        send_byte(2, 100, 8'h81, 1'b1);
        // A count above the chunk limit saturates, so chunk 63 is taken and 64 is not.
        write_expected(7'd127);
        send_byte(MAX_CHUNKS - 1, CHUNK_BYTES - 1, 8'hC3, 1'b1);
        send_byte(MAX_CHUNKS, 0, 8'h01, 1'b1);
        send_read(STORE_BYTES - 1);
        send_query(MAX_CHUNKS - 1);
    endtask

    // Mostly complete chunks with random payload, mixed with queries, reads,
    // chunks that stop short, and refused or unused commands.
    task automatic random_phase(logic [CNT_W-1:0] chunks, int budget, int idle);
        int limit;
        int done_items;
        int pick;
        int seq;
        int len;
        write_expected(chunks);
        idle_pct = idle;
        limit = (chunks > MAX_CHUNKS) ? MAX_CHUNKS : int'(chunks);
        done_items = 0;
        while (done_items < budget)
        begin
            pick = $urandom_range(0, 99);
            if (limit > 0 && $urandom_range(0, 9) != 0)
                seq = $urandom_range(0, limit - 1);
            else
                seq = $urandom_range(0, 255);
            if ($urandom_range(0, 19) == 0)
                len = $urandom_range(100, CHUNK_BYTES);
            else
                len = $urandom_range(1, 16);
            if (pick < 55)
            begin
                send_chunk(seq, len, 1'b1);
                done_items += len;
            end
            else if (pick < 62)
            begin
                send_chunk(seq, (len > 16) ? 16 : len, 1'b0);
                done_items += (len > 16) ? 16 : len;
            end
            else if (pick < 75)
            begin
                send_query(seq);
                done_items++;
            end
            else if (pick < 88)
            begin
                send_read(pick_read_address());
                done_items++;
            end
            else if (pick < 96)
            begin
                send_command(random_command(OP_DATA));
                done_items++;
            end
            else
            begin
                send_command(random_command(OP_NONE));
                done_items++;
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        start <= 1'b0;
        op <= OP_DATA;
        seq_num <= '0;
        byte_index <= '0;
        data_byte <= '0;
        last_byte <= 1'b0;
        read_address <= '0;
        idle_pct = 30;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();
        random_phase(7'd2, 150, 25);
        random_phase(7'd64, 200, 40);
        random_phase(7'd1, 100, 0);
        random_phase(7'd5, 150, 15);
        random_phase(7'd127, 200, 30);
        random_phase(CNT_W'($urandom_range(0, 127)), 150, 20);
        random_phase(7'd0, 50, 25);
        random_phase(7'd3, 120, 0);

        start <= 1'b0;
        while (mirror.status_queue.size() != 0) @(posedge clk);
        repeat (RESULT_LATENCY + 6) @(posedge clk);
        if (mirror.errors == 0 && mirror.status_queue.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
